### hdl/sfp_pkg.sv
// Shared constants, types and codes of the sensor frame parser.
package sfp_pkg;

   localparam int BUF_DEPTH = 32;
   localparam int LEN_W = $clog2(BUF_DEPTH);
   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int PAYLOAD_LEN_W = 5;
   localparam int KIND_W = 2;

   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h16;
   localparam logic [BYTE_W-1:0] CMD_FULL = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_FINE = 8'h0B;
   localparam int FULL_MIN_LEN = 12;
   localparam int FINE_MIN_LEN = 4;

   localparam int POS_CMD = 0;
   localparam int POS_FINE_HI = 3;
   localparam int POS_FINE_LO = 4;
   localparam int POS_FINEST_HI = 7;
   localparam int POS_FINEST_LO = 8;
   localparam int POS_COARSE_HI = 11;
   localparam int POS_COARSE_LO = 12;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINE = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic                     frame_ok;
      logic [BYTE_W-1:0]        command_code;
      logic [PAYLOAD_LEN_W-1:0] payload_len;
      logic [KIND_W-1:0]        reading_kind;
      logic [WORD_W-1:0]        fine_dust;
      logic [WORD_W-1:0]        finest_dust;
      logic [WORD_W-1:0]        coarse_dust;
   } result_type;

endpackage

### hdl/sfp_req_if.sv
// Channel carrying received serial bytes into the frame parser.
interface sfp_req_if;
   logic                       valid;
   logic                       ready;
   logic [sfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/sfp_rsp_if.sv
// Channel carrying decoded frame results out of the frame parser.
interface sfp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              frame_ok;
   logic [sfp_pkg::BYTE_W-1:0]        command_code;
   logic [sfp_pkg::PAYLOAD_LEN_W-1:0] payload_len;
   logic [sfp_pkg::KIND_W-1:0]        reading_kind;
   logic [sfp_pkg::WORD_W-1:0]        fine_dust;
   logic [sfp_pkg::WORD_W-1:0]        finest_dust;
   logic [sfp_pkg::WORD_W-1:0]        coarse_dust;

   modport source (output valid, output frame_ok, output command_code, output payload_len,
                   output reading_kind, output fine_dust, output finest_dust,
                   output coarse_dust, input ready);
   modport sink (input valid, input frame_ok, input command_code, input payload_len,
                 input reading_kind, input fine_dust, input finest_dust,
                 input coarse_dust, output ready);
endinterface

### hdl/sfp_in_stage.sv
// Input register stage holding one received byte until the parser takes it.
module sfp_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   sfp_req_if.sink                    req_bus,
   input  logic                       take,
   output logic                       byte_valid,
   output logic [sfp_pkg::BYTE_W-1:0] byte_data
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [sfp_pkg::BYTE_W-1:0] data_ff;
   logic                       accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_bus.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data = data_ff;

endmodule

### hdl/sfp_frame_fsm.sv
// Frame hunting state machine with running sum, payload capture and result decode.
module sfp_frame_fsm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [sfp_pkg::BYTE_W-1:0] byte_data,
   output logic                       is_check,
   output sfp_pkg::result_type        result
);

   sfp_pkg::phase_type          phase_ff, phase_in;
   logic [sfp_pkg::BYTE_W-1:0]  sum_ff, sum_in;
   logic [sfp_pkg::LEN_W-1:0]   length_ff, length_in;
   logic [sfp_pkg::LEN_W-1:0]   position_ff, position_in;
   logic [sfp_pkg::LEN_W-1:0]   position_next;
   logic [sfp_pkg::BYTE_W-1:0]  sum_total;
   logic                        length_fits;

   logic [sfp_pkg::BYTE_W-1:0]  cmd_ff;
   logic [sfp_pkg::BYTE_W-1:0]  fine_hi_ff, fine_lo_ff;
   logic [sfp_pkg::BYTE_W-1:0]  finest_hi_ff, finest_lo_ff;
   logic [sfp_pkg::BYTE_W-1:0]  coarse_hi_ff, coarse_lo_ff;

   logic                        sum_ok;
   logic [sfp_pkg::BYTE_W-1:0]  cmd_out;
   logic                        full_reading;
   logic                        fine_reading;

   assign sum_total = sum_ff + byte_data;
   assign position_next = position_ff + sfp_pkg::LEN_W'(1);
   assign length_fits = {1'b0, byte_data} < (sfp_pkg::BYTE_W + 1)'(sfp_pkg::BUF_DEPTH);

   always_comb begin
      phase_in = phase_ff;
      sum_in = sum_total;
      length_in = length_ff;
      position_in = position_ff;
      unique case (phase_ff)
         sfp_pkg::PH_HEADER: begin
            sum_in = byte_data;
            if (byte_data == sfp_pkg::HDR_BYTE) begin
               phase_in = sfp_pkg::PH_LENGTH;
            end
         end
         sfp_pkg::PH_LENGTH: begin
            if (length_fits) begin
               length_in = sfp_pkg::LEN_W'(byte_data);
               position_in = '0;
               phase_in = (byte_data != '0) ? sfp_pkg::PH_DATA : sfp_pkg::PH_CHECK;
            end else begin
               phase_in = sfp_pkg::PH_HEADER;
            end
         end
         sfp_pkg::PH_DATA: begin
            position_in = position_next;
            if (position_next >= length_ff) begin
               phase_in = sfp_pkg::PH_CHECK;
            end
         end
         sfp_pkg::PH_CHECK: begin
            phase_in = sfp_pkg::PH_HEADER;
         end
         default: begin
            phase_in = sfp_pkg::PH_HEADER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfp_pkg::PH_HEADER;
         sum_ff <= '0;
         length_ff <= '0;
         position_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         sum_ff <= sum_in;
         length_ff <= length_in;
         position_ff <= position_in;
      end
   end

   // Only the payload bytes that feed the result are kept.
   always_ff @(posedge clock) begin
      if (step && (phase_ff == sfp_pkg::PH_DATA)) begin
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_CMD)) begin
            cmd_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_FINE_HI)) begin
            fine_hi_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_FINE_LO)) begin
            fine_lo_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_FINEST_HI)) begin
            finest_hi_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_FINEST_LO)) begin
            finest_lo_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_COARSE_HI)) begin
            coarse_hi_ff <= byte_data;
         end
         if (position_ff == sfp_pkg::LEN_W'(sfp_pkg::POS_COARSE_LO)) begin
            coarse_lo_ff <= byte_data;
         end
      end
   end

   assign is_check = (phase_ff == sfp_pkg::PH_CHECK);
   assign sum_ok = (sum_total == '0);
   assign cmd_out = (length_ff != '0) ? cmd_ff : '0;
   assign full_reading = sum_ok && (cmd_out == sfp_pkg::CMD_FULL)
                         && (length_ff > sfp_pkg::LEN_W'(sfp_pkg::FULL_MIN_LEN));
   assign fine_reading = sum_ok && (cmd_out == sfp_pkg::CMD_FINE)
                         && (length_ff > sfp_pkg::LEN_W'(sfp_pkg::FINE_MIN_LEN));

   always_comb begin
      result.frame_ok = sum_ok;
      result.command_code = cmd_out;
      result.payload_len = sfp_pkg::PAYLOAD_LEN_W'(length_ff);
      result.reading_kind = sfp_pkg::KIND_NONE;
      result.fine_dust = '0;
      result.finest_dust = '0;
      result.coarse_dust = '0;
      priority if (full_reading) begin
         result.reading_kind = sfp_pkg::KIND_FULL;
         result.fine_dust = {fine_hi_ff, fine_lo_ff};
         result.finest_dust = {finest_hi_ff, finest_lo_ff};
         result.coarse_dust = {coarse_hi_ff, coarse_lo_ff};
      end else if (fine_reading) begin
         result.reading_kind = sfp_pkg::KIND_FINE;
         result.fine_dust = {fine_hi_ff, fine_lo_ff};
      end else begin
         result.reading_kind = sfp_pkg::KIND_NONE;
      end
   end

endmodule

### hdl/sensor_frame_parser_core.sv
// Top level of the sensor frame parser: input stage, frame state machine and result register.
// The check byte waits in the input stage register, and its result is then captured into the result register.
// Throughput: one byte per cycle; a result waiting in the output register stalls the
// input only when the next check byte needs that register.
// Reset (synchronous, active high) empties both stages and returns the parser to header hunting.
module sensor_frame_parser_core (
   input  logic      clock,
   input  logic      reset,
   sfp_req_if.sink   req_bus,
   sfp_rsp_if.source rsp_bus
);

   logic                       byte_valid;
   logic [sfp_pkg::BYTE_W-1:0] byte_data;
   logic                       is_check;
   sfp_pkg::result_type        result;
   logic                       out_free;
   logic                       step;
   logic                       rsp_valid_ff, rsp_valid_in;
   sfp_pkg::result_type        rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign step = byte_valid && (!is_check || out_free);

   sfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   sfp_frame_fsm u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_data (byte_data),
      .is_check  (is_check),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && is_check) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && is_check) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.frame_ok = rsp_data_ff.frame_ok;
   assign rsp_bus.command_code = rsp_data_ff.command_code;
   assign rsp_bus.payload_len = rsp_data_ff.payload_len;
   assign rsp_bus.reading_kind = rsp_data_ff.reading_kind;
   assign rsp_bus.fine_dust = rsp_data_ff.fine_dust;
   assign rsp_bus.finest_dust = rsp_data_ff.finest_dust;
   assign rsp_bus.coarse_dust = rsp_data_ff.coarse_dust;

endmodule
